/* rtl/core/tppt_pkg.sv */
package tppt_pkg;

    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_V4   = 2'd1;
    localparam logic [1:0] FAM_V6   = 2'd2;

    localparam logic [7:0] V4_BITS = 8'd32;
    localparam logic [7:0] V6_BITS = 8'd128;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_CLEAR     = 2'd0,
        FUNC_ADD       = 2'd1,
        FUNC_MATCH     = 2'd2,
        FUNC_EFFECTIVE = 2'd3
    } func_t;

    typedef enum logic {
        BK_IDLE,
        BK_EVAL
    } back_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  addr_family;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  pfx_len;
        logic [1:0]  fwd_family;
        logic [63:0] fwd_hi;
        logic [63:0] fwd_lo;
    } tppt_in_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  out_family;
        logic [63:0] out_hi;
        logic [63:0] out_lo;
    } tppt_out_t;

    // Request after classification: families folded, IPv4 values cut to 32 bits,
    // and the prefix length turned into a bit mask.
    typedef struct packed {
        func_t       func;
        logic [1:0]  fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [1:0]  ffam;
        logic [63:0] fhi;
        logic [63:0] flo;
        logic [63:0] mask_hi;
        logic [63:0] mask_lo;
        logic        add_legal;
    } tppt_op_t;

endpackage

/* rtl/core/tppt_front.sv */
module tppt_front
    import tppt_pkg::*;
(
    input  logic     s_valid,
    output logic     s_ready,
    input  tppt_in_t s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output tppt_op_t push_data
);

    logic [31:0]  v4_mask;
    logic [127:0] v6_mask;

    assign v4_mask = ~(32'hFFFF_FFFF >> s_data.pfx_len);
    assign v6_mask = ~({128{1'b1}} >> s_data.pfx_len);

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data           = '0;
        push_data.func      = func_t'(s_data.func);
        push_data.fam       = FAM_NONE;
        push_data.hi        = s_data.addr_hi;
        push_data.lo        = s_data.addr_lo;
        push_data.add_legal = 1'b0;
        case (s_data.addr_family)
            FAM_V4: begin
                push_data.fam       = FAM_V4;
                push_data.hi        = '0;
                push_data.lo        = {32'b0, s_data.addr_lo[31:0]};
                push_data.mask_hi   = '0;
                push_data.mask_lo   = {32'b0, v4_mask};
                push_data.add_legal = (s_data.pfx_len <= V4_BITS);
            end
            FAM_V6: begin
                push_data.fam       = FAM_V6;
                push_data.mask_hi   = v6_mask[127:64];
                push_data.mask_lo   = v6_mask[63:0];
                push_data.add_legal = (s_data.pfx_len <= V6_BITS);
            end
            default: begin
                push_data.fam = FAM_NONE;
            end
        endcase
        push_data.ffam = FAM_NONE;
        push_data.fhi  = s_data.fwd_hi;
        push_data.flo  = s_data.fwd_lo;
        case (s_data.fwd_family)
            FAM_V4: begin
                push_data.ffam = FAM_V4;
                push_data.fhi  = '0;
                push_data.flo  = {32'b0, s_data.fwd_lo[31:0]};
            end
            FAM_V6: begin
                push_data.ffam = FAM_V6;
            end
            default: begin
                push_data.ffam = FAM_NONE;
            end
        endcase
    end

endmodule

/* rtl/core/tppt_queue.sv */
module tppt_queue
    import tppt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  tppt_op_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output tppt_op_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tppt_op_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/tppt_back.sv */
module tppt_back
    import tppt_pkg::*;
#(
    parameter int RULES = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  tppt_op_t  pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tppt_out_t m_data
);

    localparam int CNT_W = $clog2(RULES + 1);
    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

    back_state_t      state_reg;
    back_state_t      state_next;

    logic [1:0]       rule_fam_reg     [RULES];
    logic [63:0]      rule_net_hi_reg  [RULES];
    logic [63:0]      rule_net_lo_reg  [RULES];
    logic [63:0]      rule_mask_hi_reg [RULES];
    logic [63:0]      rule_mask_lo_reg [RULES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    tppt_op_t         work_reg;
    logic [RULES-1:0] hit_reg;
    logic [RULES-1:0] hit_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    tppt_out_t        out_data_reg;
    tppt_out_t        result;

    logic             load_work;
    logic             finish;
    logic             matched;
    logic             table_full;
    logic             do_add;
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        for (int i = 0; i < RULES; i++) begin
            hit_next[i] = (count_reg > CNT_W'(i))
                && (rule_fam_reg[i] == pop_data.fam)
                && (((pop_data.hi ^ rule_net_hi_reg[i]) & rule_mask_hi_reg[i]) == '0)
                && (((pop_data.lo ^ rule_net_lo_reg[i]) & rule_mask_lo_reg[i]) == '0);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        pop_ready = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
            end
            BK_EVAL: begin
                finish = !out_valid_reg || m_ready;
            end
            default: begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign load_work  = pop_valid && pop_ready;
    assign matched    = |hit_reg;
    assign table_full = (count_reg == CNT_W'(RULES));
    assign wr_idx     = count_reg[IDX_W-1:0];

    always_comb begin
        result     = '0;
        do_add     = 1'b0;
        count_next = count_reg;
        case (work_reg.func)
            FUNC_CLEAR: begin
                count_next = '0;
            end
            FUNC_ADD: begin
                do_add    = work_reg.add_legal && !table_full;
                result.ok = do_add;
                if (do_add) begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_MATCH: begin
                result.ok = matched;
            end
            FUNC_EFFECTIVE: begin
                if (work_reg.fam != FAM_NONE) begin
                    if (matched && (work_reg.ffam != FAM_NONE)
                            && ((work_reg.fhi | work_reg.flo) != '0)) begin
                        result.ok         = 1'b1;
                        result.out_family = work_reg.ffam;
                        result.out_hi     = work_reg.fhi;
                        result.out_lo     = work_reg.flo;
                    end else begin
                        result.out_family = work_reg.fam;
                        result.out_hi     = work_reg.hi;
                        result.out_lo     = work_reg.lo;
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_work) begin
            work_reg <= pop_data;
            hit_reg  <= hit_next;
        end
        if (finish) begin
            out_data_reg <= result;
        end
        if (finish && do_add) begin
            rule_fam_reg[wr_idx]     <= work_reg.fam;
            rule_net_hi_reg[wr_idx]  <= work_reg.hi;
            rule_net_lo_reg[wr_idx]  <= work_reg.lo;
            rule_mask_hi_reg[wr_idx] <= work_reg.mask_hi;
            rule_mask_lo_reg[wr_idx] <= work_reg.mask_lo;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* rtl/core/trusted_proxy_prefix_table.sv */
// Trusted-proxy prefix table. Each request on the s_ channel carries one of four
// functions: clear the table, add a prefix rule, match a peer address, or pick the
// effective client address. Every request yields exactly one response on the m_
// channel, in request order, carrying ok and the effective address fields.
// The front stage folds families and turns the prefix length into a bit mask,
// then writes the request into a two-entry queue. The back stage pops a request,
// compares it against all stored rules in parallel and registers the hit vector,
// then in its BK_EVAL state forms the response and commits any table update.
// A request passes the queue slot, the back stage's work and hit registers and
// the output register. The back stage takes a new request only after it has
// committed the last, so its compare-then-commit sequence keeps a request from
// seeing a stale table. When the receiver stalls, the response waits in the output
// register, the back stage holds the next request with its compare done, and the
// queue goes on taking up to two more requests before s_ready drops. Reset empties
// the table and the queue and clears the pending response; it takes effect in the
// cycle after aresetn is sampled low.
module trusted_proxy_prefix_table
    import tppt_pkg::*;
#(
    parameter int RULES = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tppt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tppt_out_t m_data
);

    logic     push_valid;
    logic     push_ready;
    tppt_op_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    tppt_op_t pop_data;

    tppt_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tppt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tppt_back #(
        .RULES (RULES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
